[rtl/core/wpm_pkg.sv]
// Wildcard pattern matcher: shared types, constants and pattern alignment.
// Used by every module under rtl/core; no dependencies.
`default_nettype none

package wpm_pkg;

  localparam int PATTERN_MAX    = 48;
  localparam int WIN            = PATTERN_MAX - 1;
  localparam int SYM_W          = 5;
  localparam int LEN_W          = 6;
  localparam int POS_W          = 32;
  localparam int OUT_W          = 32;
  localparam int CHARS_PER_WORD = 12;
  localparam int WORD_W         = CHARS_PER_WORD * SYM_W;
  localparam int NUM_WORDS      = PATTERN_MAX / CHARS_PER_WORD;
  localparam int CFG_DW         = 64;
  localparam int CFG_AW         = 6;
  localparam int IN_DW          = 8;

  localparam logic [SYM_W-1:0] LETTER_COUNT = SYM_W'(26);
  localparam logic [SYM_W-1:0] WILDCARD     = SYM_W'(31);
  localparam logic [LEN_W-1:0] LEN_MAX      = LEN_W'(PATTERN_MAX);
  localparam logic [LEN_W-1:0] LEN_RESET    = LEN_W'(1);

  typedef enum logic [2:0] {
    REG_LENGTH = 3'd0,
    REG_WORD0  = 3'd1,
    REG_WORD1  = 3'd2,
    REG_WORD2  = 3'd3,
    REG_WORD3  = 3'd4
  } wpm_reg_t;

  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] wpm_words_t;

  // chars[d] is the pattern character compared with the symbol d places back
  typedef struct packed {
    logic [LEN_W-1:0]                  len;
    logic [PATTERN_MAX-1:0][SYM_W-1:0] chars;
  } wpm_pat_t;

  function automatic logic char_ok(logic [SYM_W-1:0] pc, logic [SYM_W-1:0] s);
    return (pc >= LETTER_COUNT) || (pc == s);
  endfunction

  function automatic wpm_pat_t align_pattern(logic [LEN_W-1:0] len_raw, wpm_words_t words);
    logic [PATTERN_MAX-1:0][SYM_W-1:0] src;
    logic [LEN_W-1:0]                  len;
    logic [LEN_W-1:0]                  idx;
    wpm_pat_t                          p;
    src = words;
    if (len_raw == '0) begin
      len = LEN_W'(1);
    end else if (len_raw > LEN_MAX) begin
      len = LEN_MAX;
    end else begin
      len = len_raw;
    end
    p.len = len;
    for (int d = 0; d < PATTERN_MAX; d++) begin
      idx = len - LEN_W'(1) - LEN_W'(d);
      if (LEN_W'(d) < len) begin
        p.chars[d] = src[idx];
      end else begin
        p.chars[d] = WILDCARD;
      end
    end
    return p;
  endfunction

endpackage

`default_nettype wire

[rtl/core/wpm_cell.sv]
// One window cell: holds a past symbol, compares it with its pattern character
// and passes the symbol on. Depends on wpm_pkg.
`default_nettype none

module wpm_cell
  import wpm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             shift_en,
  input  wire logic [SYM_W-1:0] sym_in,
  input  wire logic [SYM_W-1:0] pat_char,
  output logic      [SYM_W-1:0] sym_out,
  output logic                  ok
);

  logic [SYM_W-1:0] sym_r;
  logic [SYM_W-1:0] sym_nxt;

  assign sym_nxt = shift_en ? sym_in : sym_r;

  always_ff @(posedge clk) begin
    sym_r <= sym_nxt;
  end

  assign sym_out = sym_r;
  assign ok      = char_ok(pat_char, sym_r);

endmodule

`default_nettype wire

[rtl/core/wpm_cfg.sv]
// Configuration registers behind the APB-style port, plus the pattern
// realigned to window order on every write. Depends on wpm_pkg.
`default_nettype none

module wpm_cfg
  import wpm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready,
  output wpm_pat_t               pat
);

  logic [LEN_W-1:0] len_r,   len_nxt;
  wpm_words_t       words_r, words_nxt;
  wpm_pat_t         pat_r,   pat_nxt;
  logic             wr_en;
  wpm_reg_t         reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = wpm_reg_t'(cfg_paddr[CFG_AW-1:3]);

  always_comb begin
    len_nxt   = len_r;
    words_nxt = words_r;
    if (wr_en) begin
      unique case (reg_sel)
        REG_LENGTH: len_nxt      = cfg_pwdata[LEN_W-1:0];
        REG_WORD0:  words_nxt[0] = cfg_pwdata[WORD_W-1:0];
        REG_WORD1:  words_nxt[1] = cfg_pwdata[WORD_W-1:0];
        REG_WORD2:  words_nxt[2] = cfg_pwdata[WORD_W-1:0];
        REG_WORD3:  words_nxt[3] = cfg_pwdata[WORD_W-1:0];
        default:    ;
      endcase
    end
    pat_nxt = align_pattern(len_nxt, words_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= LEN_RESET;
      words_r <= '0;
      pat_r   <= align_pattern(LEN_RESET, '0);
    end else begin
      len_r   <= len_nxt;
      words_r <= words_nxt;
      pat_r   <= pat_nxt;
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_LENGTH: cfg_prdata = CFG_DW'(len_r);
      REG_WORD0:  cfg_prdata = CFG_DW'(words_r[0]);
      REG_WORD1:  cfg_prdata = CFG_DW'(words_r[1]);
      REG_WORD2:  cfg_prdata = CFG_DW'(words_r[2]);
      REG_WORD3:  cfg_prdata = CFG_DW'(words_r[3]);
      default:    cfg_prdata = '0;
    endcase
  end

  assign pat = pat_r;

endmodule

`default_nettype wire

[rtl/core/wildcard_pattern_matcher.sv]
// Wildcard pattern matcher top level: symbol window as a row of cells,
// configuration block and registered result stage. Depends on wpm_pkg,
// wpm_cfg and wpm_cell.
//
// Usage:
//   in_*  : one text symbol per word. in_tdata[4:0] symbol (0 = a .. 25 = z),
//           in_tuser restart (word opens a new text at position zero).
//   out_* : one word per match, out_tdata = start position of the match.
//   cfg_* : APB-style registers at 8*i: length, then pattern words 0..3
//           (12 five-bit characters each, codes 26-31 are the wildcard).
// Throughput: one symbol per cycle while out_* is not stalled; all window
// cells compare in parallel against the realigned pattern: no iteration.
// Latency: a match is offered on out_* the cycle after the symbol that
// completes it is accepted.
// Stall: a single output register holds the pending match; a new symbol is
// taken whenever that register is empty or is drained in the same cycle.
// Reset: length 1, pattern all 'a', position zero, no result pending.
// Configure only while no word is in flight.
`default_nettype none

module wildcard_pattern_matcher
  import wpm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_DW-1:0]  in_tdata,   // [4:0] symbol, [7:5] zero
  input  wire logic              in_tuser,   // [0] restart
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [OUT_W-1:0]  out_tdata,  // [31:0] match_start
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  localparam logic [POS_W-1:0] POS_MAX = '1;

  wpm_pat_t         pat;
  logic             acc;
  logic [SYM_W-1:0] sym;
  logic [WIN:0][SYM_W-1:0] chain;
  logic [WIN:0]     ok;
  logic [POS_W-1:0] seen_r, seen_nxt;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] span;
  logic             hit;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r,  out_data_nxt;

  wpm_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .pat         (pat)
  );

  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;
  assign sym       = in_tdata[SYM_W-1:0];

  assign chain[0] = sym;
  assign ok[0]    = char_ok(pat.chars[0], sym);

  for (genvar k = 0; k < WIN; k++) begin : g_cell
    wpm_cell u_cell (
      .clk      (clk),
      .shift_en (acc),
      .sym_in   (chain[k]),
      .pat_char (pat.chars[k+1]),
      .sym_out  (chain[k+1]),
      .ok       (ok[k+1])
    );
  end

  assign pos  = in_tuser ? '0 : seen_r;
  assign span = POS_W'(pat.len - LEN_W'(1));
  assign hit  = (&ok) && (pos >= span);

  always_comb begin
    seen_nxt = seen_r;
    if (acc) begin
      seen_nxt = (pos != POS_MAX) ? pos + POS_W'(1) : pos;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (acc) begin
      out_valid_nxt = hit;
      out_data_nxt  = OUT_W'(pos - span);
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_restart_short: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_tuser && pat.len != LEN_W'(1)) |-> !hit)
    else $error("match reported before a full pattern of a new text");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !in_tuser && seen_r != POS_MAX) |=> seen_r == $past(seen_r) + POS_W'(1))
    else $error("position counter did not advance");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> seen_r == $past(seen_r))
    else $error("position counter moved without a word");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with an empty result register");

  a_hit_span: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && hit) |=> out_tvalid && out_tdata == OUT_W'($past(pos) - $past(span)))
    else $error("match not loaded into the result register");

endmodule

`default_nettype wire

[bench/wildcard_pattern_matcher_tb.sv]
// Self-checking bench for wildcard_pattern_matcher: streams text symbols under
// a series of patterns and compares every match start with its own predictor.
// Depends on wpm_pkg and the wildcard_pattern_matcher RTL.
`default_nettype none

module wildcard_pattern_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wpm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 14;

  class match_tracker;
    logic [LEN_W-1:0]  len_raw;
    logic [WORD_W-1:0] words [NUM_WORDS];
    logic [SYM_W-1:0]  window [WIN];
    logic [POS_W-1:0]  position;
    logic [OUT_W-1:0]  pending_starts [$];
    int                errors;
    int                checked;

    function new();
      len_raw = LEN_RESET;
      foreach (words[i]) words[i] = '0;
      foreach (window[i]) window[i] = '0;
      position = '0;
      errors   = 0;
      checked  = 0;
    endfunction

    function int span();
      if (len_raw == '0) return 1;
      if (len_raw > LEN_MAX) return PATTERN_MAX;
      return int'(len_raw);
    endfunction

    function void set_reg(wpm_reg_t r, logic [CFG_DW-1:0] v);
      if (r == REG_LENGTH) begin
        len_raw = v[LEN_W-1:0];
      end else begin
        words[int'(r) - int'(REG_WORD0)] = v[WORD_W-1:0];
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    task take_symbol(logic [SYM_W-1:0] s, logic restart);
      int               n;
      int               d;
      logic [SYM_W-1:0] pc;
      logic [SYM_W-1:0] tc;
      logic [POS_W-1:0] pos;
      bit               hit;
      n = span();
      if (restart) position = '0;
      pos = position;
      hit = (pos >= POS_W'(n - 1));
      for (int k = 0; k < n && hit; k++) begin
        d  = n - 1 - k;
        pc = words[k / CHARS_PER_WORD][SYM_W * (k % CHARS_PER_WORD) +: SYM_W];
        if (d == 0) begin
          tc = s;
        end else begin
          tc = window[d - 1];
        end
        if (pc < LETTER_COUNT && pc != tc) hit = 1'b0;
      end
      for (int i = WIN - 1; i > 0; i--) window[i] = window[i - 1];
      window[0] = s;
      if (position != '1) position = pos + 1'b1;
      if (hit) pending_starts = {pending_starts, OUT_W'(pos - POS_W'(n - 1))};
    endtask

    task check_start(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      if (pending_starts.size() == 0) begin
        report($sformatf("match at %0d with none expected", got));
      end else begin
        want = pending_starts.pop_front();
        checked++;
        if (got !== want) report($sformatf("match_start %0d, expected %0d", got, want));
      end
    endtask

    task flush_leftover();
      if (pending_starts.size() != 0) begin
        report($sformatf("%0d expected matches never came", pending_starts.size()));
      end
    endtask
  endclass

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata    = '0;   // [4:0] symbol, [7:5] zero
  logic              in_tuser    = 1'b0; // [0] restart
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [OUT_W-1:0]  out_tdata;          // [31:0] match_start
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [CFG_DW-1:0] cfg_pwdata  = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  match_tracker     tracker = new();
  logic [SYM_W-1:0] pat [PATTERN_MAX];
  int               burst_left    = 0;
  int               symbols_sent  = 0;
  int               settings      = 0;
  int unsigned      cycles        = 0;
  bit               hold_req      = 1'b0;
  bit               holding       = 1'b0;

  wildcard_pattern_matcher dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_start(out_tdata);
    if (rst_n && in_tvalid && in_tready) tracker.take_symbol(in_tdata[SYM_W-1:0], in_tuser);
  end

  initial begin : stall_pattern
    int run;
    int mode;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        holding  = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        run  = $urandom_range(1, 40);
        repeat (run) begin
          case (mode)
            0:       out_tready <= 1'b1;
            1:       out_tready <= 1'($urandom_range(0, 1));
            2:       out_tready <= ($urandom_range(0, 3) == 0);
            default: out_tready <= ($urandom_range(0, 7) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  task automatic rest(input int n);
    in_tvalid <= 1'b0;
    in_tdata  <= IN_DW'($urandom_range(0, 31));
    repeat (n) @(posedge clk);
  endtask

  task automatic put_symbol(input logic [SYM_W-1:0] s, input logic restart);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) rest(gap);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DW'(s);
    in_tuser  <= restart;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    symbols_sent++;
  endtask

  // hold the input until every predicted match has been taken
  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (tracker.pending_starts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input wpm_reg_t r, input logic [CFG_DW-1:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'(8 * int'(r));
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    tracker.set_reg(r, v);
  endtask

  task automatic configure(input logic [LEN_W-1:0] len_raw);
    logic [WORD_W-1:0] w [NUM_WORDS];
    drain();
    for (int k = 0; k < PATTERN_MAX; k++) begin
      w[k / CHARS_PER_WORD][SYM_W * (k % CHARS_PER_WORD) +: SYM_W] = pat[k];
    end
    for (int i = 0; i < NUM_WORDS; i++) begin
      write_reg(wpm_reg_t'(int'(REG_WORD0) + i), CFG_DW'(w[i]));
    end
    write_reg(REG_LENGTH, CFG_DW'(len_raw));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    settings++;
  endtask

  function automatic logic [SYM_W-1:0] text_symbol(input int alpha);
    if ($urandom_range(0, 59) == 0) return SYM_W'($urandom_range(26, 31));
    return SYM_W'($urandom_range(0, alpha - 1));
  endfunction

  // style 0: random pattern, 1: all wildcard, 2: all 'a' over a text of 'a' with rare codes 26-31
  task automatic random_phase(input int items, input logic [LEN_W-1:0] len_raw,
                              input int style);
    int               alpha;
    int               wild_pct;
    int               n;
    int               sent;
    int               run;
    int               kind;
    logic [SYM_W-1:0] s;
    alpha    = (style == 2) ? 1 : (($urandom_range(0, 4) == 0) ? 26 : $urandom_range(1, 3));
    wild_pct = $urandom_range(0, 40);
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (style == 1) begin
        pat[k] = WILDCARD;
      end else if (style == 2) begin
        pat[k] = '0;
      end else if ($urandom_range(0, 99) < wild_pct) begin
        pat[k] = SYM_W'($urandom_range(26, 31));
      end else begin
        pat[k] = SYM_W'($urandom_range(0, alpha - 1));
      end
    end
    configure(len_raw);
    n    = tracker.span();
    sent = 0;
    while (sent < items) begin
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        run = $urandom_range(1, 6);
      end else if (kind == 3) begin
        run = $urandom_range(0, n - 1);
      end else begin
        run = n;
      end
      for (int k = 0; k < run; k++) begin
        if (kind < 3 || pat[k] >= LETTER_COUNT) begin
          s = text_symbol(alpha);
        end else begin
          s = pat[k];
        end
        put_symbol(s, ($urandom_range(0, 59) == 0));
      end
      sent += run;
    end
  endtask

  initial begin : stimulus
    logic [LEN_W-1:0] len_plan [PHASES];
    int               style;
    len_plan = '{6'd1, 6'd48, 6'd63, 6'd0, 6'd2, 6'd3, 6'd49, 6'd5,
                 6'd12, 6'd4, 6'd24, 6'd7, 6'd36, 6'd2};
    foreach (pat[k]) pat[k] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    rest(2);

    // reset pattern: length one, letter a
    put_symbol(5'd0, 1'b1);
    put_symbol(5'd25, 1'b0);
    put_symbol(WILDCARD, 1'b0);
    put_symbol(5'd0, 1'b0);

    // a?c with the lowest wildcard code, short text after a restart
    pat[0] = 5'd0;
    pat[1] = LETTER_COUNT;
    pat[2] = 5'd2;
    configure(6'd3);
    put_symbol(5'd0, 1'b1);
    put_symbol(5'd1, 1'b0);
    put_symbol(5'd2, 1'b0);
    put_symbol(5'd0, 1'b0);
    put_symbol(WILDCARD, 1'b0);
    put_symbol(5'd2, 1'b0);
    put_symbol(5'd2, 1'b1);

    // length zero acts as one
    pat[0] = WILDCARD;
    configure(6'd0);
    put_symbol(WILDCARD, 1'b0);
    put_symbol(5'd25, 1'b1);
    put_symbol(5'd0, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      style = (p == 1) ? 1 : ((p == 2) ? 2 : 0);
      random_phase(105, len_plan[p], style);
    end

    // long output stall with a match on every symbol
    foreach (pat[k]) pat[k] = WILDCARD;
    configure(6'd1);
    hold_req = 1'b1;
    wait (holding);
    burst_left = 1000;
    repeat (80) put_symbol(SYM_W'($urandom_range(0, 31)), 1'b0);
    drain();

    for (int w = 0; w < 5000 && tracker.pending_starts.size() != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    tracker.flush_leftover();
    $display("run covered %0d symbols under %0d pattern settings (lengths 0 to 63),",
             symbols_sent, settings);
    $display("%0d match starts checked, %0d mismatches, one long output stall",
             tracker.checked, tracker.errors);
    if (tracker.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/core/wpm_pkg.sv
rtl/core/wpm_cell.sv
rtl/core/wpm_cfg.sv
rtl/core/wildcard_pattern_matcher.sv
bench/wildcard_pattern_matcher_tb.sv
